@@ design/hid_report_to_key_events_top_defines.svh @@
// assertion macros for the keyboard report event block
`ifndef HID_REPORT_TO_KEY_EVENTS_TOP_DEFINES_SVH
`define HID_REPORT_TO_KEY_EVENTS_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HRKE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HRKE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/hrke_pkg.sv @@
// shared types, constants and key code table for the keyboard report event block
package hrke_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int MOD_COUNT = 6;
  localparam int N_EVENTS  = MOD_COUNT + 2 * KEY_SLOTS;
  localparam int ROM_SIZE  = 138;

  typedef logic [N_EVENTS-1:0] ev_vec_t;
  typedef logic [KEY_SLOTS-1:0][7:0] key_list_t;

  localparam ev_vec_t EV_ONE = ev_vec_t'(1);

  // one event per possible source: modifiers, then presses, then releases
  typedef struct packed {
    ev_vec_t                   mask;
    ev_vec_t                   down;
    logic [N_EVENTS-1:0][7:0]  vk;
  } ev_table_t;

  typedef struct packed {
    logic busy;
    logic can_load;
  } ser_status_t;

  localparam logic [7:0] MOD_MASK [MOD_COUNT] = '{
    8'h01, 8'h02, 8'h04, 8'h10, 8'h20, 8'h40
  };
  localparam logic [7:0] MOD_VK [MOD_COUNT] = '{
    8'h11, 8'hA0, 8'h12, 8'hA3, 8'hA1, 8'hA5
  };

  localparam logic [7:0] VK_ROM [ROM_SIZE] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
    8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
    8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h0D, 8'h1B, 8'h08, 8'h09, 8'h20, 8'hBD, 8'hDE, 8'hC0, 8'hDB, 8'hDC,
    8'hDD, 8'hBB, 8'hBA, 8'hC0, 8'hBC, 8'hBE, 8'hBF, 8'h14, 8'h70, 8'h71,
    8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h7B,
    8'h2C, 8'h91, 8'h13, 8'h2D, 8'h24, 8'h21, 8'h2E, 8'h23, 8'h22, 8'h27,
    8'h25, 8'h28, 8'h26, 8'h00, 8'h6F, 8'h6A, 8'h6D, 8'h6B, 8'h6C, 8'h61,
    8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h60, 8'h6E,
    8'h6E, 8'hDC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE2, 8'h15, 8'hDC
  };

  function automatic logic [7:0] vk_translate(input logic [7:0] code);
    logic [7:0] vk;
    vk = 8'h00;
    if (code < 8'(ROM_SIZE)) begin
      vk = VK_ROM[code];
    end
    return vk;
  endfunction

endpackage

@@ design/hrke_event_gen.sv @@
// compares a report with the previous one and builds the table of pending events
module hrke_event_gen (
  input  logic              [7:0] mods,
  input  hrke_pkg::key_list_t     keys,
  input  logic              [7:0] prev_mods,
  input  hrke_pkg::key_list_t     prev_keys,
  output hrke_pkg::ev_table_t     table_o
);

  logic [hrke_pkg::KEY_SLOTS-1:0] cur_in_prev;
  logic [hrke_pkg::KEY_SLOTS-1:0] prev_in_cur;
  logic [hrke_pkg::KEY_SLOTS-1:0][7:0] cur_vk;
  logic [hrke_pkg::KEY_SLOTS-1:0][7:0] prev_vk;

  always_comb begin
    for (int i = 0; i < hrke_pkg::KEY_SLOTS; i++) begin
      cur_in_prev[i] = 1'b0;
      prev_in_cur[i] = 1'b0;
      for (int j = 0; j < hrke_pkg::KEY_SLOTS; j++) begin
        if (keys[i] == prev_keys[j]) cur_in_prev[i] = 1'b1;
        if (prev_keys[i] == keys[j]) prev_in_cur[i] = 1'b1;
      end
      cur_vk[i]  = hrke_pkg::vk_translate(keys[i]);
      prev_vk[i] = hrke_pkg::vk_translate(prev_keys[i]);
    end
  end

  always_comb begin
    table_o = '0;
    for (int m = 0; m < hrke_pkg::MOD_COUNT; m++) begin
      table_o.mask[m] = |((mods ^ prev_mods) & hrke_pkg::MOD_MASK[m]);
      table_o.down[m] = |(mods & hrke_pkg::MOD_MASK[m]);
      table_o.vk[m]   = hrke_pkg::MOD_VK[m];
    end
    for (int i = 0; i < hrke_pkg::KEY_SLOTS; i++) begin
      // new press: non-empty, absent last time, and translatable
      table_o.mask[hrke_pkg::MOD_COUNT + i] =
        (keys[i] != 8'h00) && !cur_in_prev[i] && (cur_vk[i] != 8'h00);
      table_o.down[hrke_pkg::MOD_COUNT + i] = 1'b1;
      table_o.vk[hrke_pkg::MOD_COUNT + i]   = cur_vk[i];
      table_o.mask[hrke_pkg::MOD_COUNT + hrke_pkg::KEY_SLOTS + i] =
        (prev_keys[i] != 8'h00) && !prev_in_cur[i] && (prev_vk[i] != 8'h00);
      table_o.down[hrke_pkg::MOD_COUNT + hrke_pkg::KEY_SLOTS + i] = 1'b0;
      table_o.vk[hrke_pkg::MOD_COUNT + hrke_pkg::KEY_SLOTS + i]   = prev_vk[i];
    end
  end

endmodule

@@ design/hrke_serializer.sv @@
// holds one event table and sends its events out one word per cycle while the receiver is ready
module hrke_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  hrke_pkg::ev_table_t   table_i,
  output hrke_pkg::ser_status_t status,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic            [7:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  hrke_pkg::ev_vec_t mask_r, mask_nxt;
  hrke_pkg::ev_vec_t down_r;
  logic [hrke_pkg::N_EVENTS-1:0][7:0] vk_r;
  hrke_pkg::ev_vec_t lowest;
  hrke_pkg::ev_vec_t remaining;
  logic [7:0] sel_vk;
  logic       sel_down;
  logic       out_load;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_vk_r;
  logic       out_down_r;
  logic       out_last_r;

  assign lowest    = mask_r & ((~mask_r) + hrke_pkg::EV_ONE);
  assign remaining = mask_r & ~lowest;

  always_comb begin
    sel_vk   = 8'h00;
    sel_down = 1'b0;
    for (int i = 0; i < hrke_pkg::N_EVENTS; i++) begin
      sel_vk   = sel_vk | (vk_r[i] & {8{lowest[i]}});
      sel_down = sel_down | (down_r[i] & lowest[i]);
    end
  end

  assign out_load        = (|mask_r) && (!out_valid_r || out_tready);
  assign status.busy     = |mask_r;
  assign status.can_load = (remaining == '0) && (!(|mask_r) || out_load);

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = table_i.mask;
    end else if (out_load) begin
      mask_nxt = remaining;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      down_r <= table_i.down;
      vk_r   <= table_i.vk;
    end
    if (out_load) begin
      out_vk_r   <= sel_vk;
      out_down_r <= sel_down;
      out_last_r <= (remaining == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_vk_r;
  assign out_tuser  = out_down_r;
  assign out_tlast  = out_last_r;

endmodule

@@ design/hid_report_to_key_events_top.sv @@
// keyboard boot report to key press and release events, top level
//
// in_*: one boot keyboard report per word (modifier byte and six key slots)
// out_*: one key event per word; tuser is 1 for a press, 0 for a release,
// tdata is the virtual key code and tlast marks the report's final event.
// A report that changes nothing produces no output word at all.
// Events leave in order: modifier edges, new presses in slot order, then
// releases in the previous report's slot order.
// A report taken goes from the input register to the event mask register,
// and its first event then to the output register. A report causes 0 to 18
// events; one report per cycle is taken when reports cause at most one
// event and the receiver does not stall; the single-event-per-cycle output
// register sets the rate otherwise.
// Reset clears the previous report to all zeros and empties every stage.
// When the receiver stalls, the current event is held and the next report
// waits in the input register; in_tready drops once both are full.
`include "hid_report_to_key_events_top_defines.svh"

module hid_report_to_key_events_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // modifiers, key_slot_0 .. key_slot_5, 8 bits each from the lowest bit up
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // virtual_key
  output logic  [7:0] out_tdata,
  // key_down
  output logic        out_tuser,
  output logic        out_tlast
);

  logic                  in_valid_r, in_valid_nxt;
  logic            [7:0] in_mods_r;
  hrke_pkg::key_list_t   in_keys_r;
  logic            [7:0] prev_mods_r;
  hrke_pkg::key_list_t   prev_keys_r;
  hrke_pkg::ev_table_t   ev_table;
  hrke_pkg::ser_status_t ser_status;
  logic                  table_load;
  logic                  in_fire;

  assign table_load   = in_valid_r && ser_status.can_load;
  assign in_tready    = !in_valid_r || table_load;
  assign in_fire      = in_tvalid && in_tready;
  assign in_valid_nxt = in_fire || (in_valid_r && !table_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      prev_mods_r <= 8'h00;
      prev_keys_r <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      // the report becomes the previous one as its events are committed
      if (table_load) begin
        prev_mods_r <= in_mods_r;
        prev_keys_r <= in_keys_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_mods_r <= in_tdata[7:0];
      in_keys_r <= in_tdata[55:8];
    end
  end

  hrke_event_gen u_event_gen (
    .mods      (in_mods_r),
    .keys      (in_keys_r),
    .prev_mods (prev_mods_r),
    .prev_keys (prev_keys_r),
    .table_o   (ev_table)
  );

  hrke_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (table_load),
    .table_i    (ev_table),
    .status     (ser_status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `HRKE_ASSERT_NEXT(a_prev_follows_load, table_load,
    (prev_mods_r == $past(in_mods_r)) && (prev_keys_r == $past(in_keys_r)),
    "previous report not updated on table load")
  `HRKE_ASSERT_IMPL(a_more_pending, out_tvalid && !out_tlast, ser_status.busy,
    "non-final event shown with no events pending")
  `HRKE_ASSERT_IMPL(a_load_only_when_drained, table_load && ser_status.busy,
    out_tvalid == 1'b0 || out_tready,
    "event table replaced while an event could not move on")

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the keyboard report to key event block
`timescale 1ns / 1ps

module tb_top;

  localparam real CLK_PERIOD   = 4.0;
  localparam int  SLOTS        = 6;
  localparam int  USAGE_CODES  = 138;
  localparam int  DIR_ROWS     = 22;
  localparam int  RANDOM_ITEMS = 450;
  localparam int  COMPUTED     = -1;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  LIMIT_NS     = 2_000_000;

  typedef struct packed {
    logic       down;
    logic [7:0] vk;
    logic       last;
  } key_ev_t;

  typedef struct {
    logic [55:0] report;
    int          n_typed;
    key_ev_t     ev0;
    key_ev_t     ev1;
  } stim_row_t;

  localparam key_ev_t NO_EV = '0;

  // modifier bit positions and their virtual keys, in event order
  localparam int         MOD_BIT  [6] = '{0, 1, 2, 4, 5, 6};
  localparam logic [7:0] MOD_KEYS [6] = '{8'h11, 8'hA0, 8'h12, 8'hA3, 8'hA1, 8'hA5};

  localparam logic [7:0] VK_OF_USAGE [USAGE_CODES] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
    8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
    8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h0D, 8'h1B, 8'h08, 8'h09, 8'h20, 8'hBD, 8'hDE, 8'hC0, 8'hDB, 8'hDC,
    8'hDD, 8'hBB, 8'hBA, 8'hC0, 8'hBC, 8'hBE, 8'hBF, 8'h14, 8'h70, 8'h71,
    8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h7B,
    8'h2C, 8'h91, 8'h13, 8'h2D, 8'h24, 8'h21, 8'h2E, 8'h23, 8'h22, 8'h27,
    8'h25, 8'h28, 8'h26, 8'h00, 8'h6F, 8'h6A, 8'h6D, 8'h6B, 8'h6C, 8'h61,
    8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h60, 8'h6E,
    8'h6E, 8'hDC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE2, 8'h15, 8'hDC
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic  [7:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // predictor state: the report last taken in
  logic [7:0]            held_mods;
  logic [SLOTS-1:0][7:0] held_keys;
  key_ev_t               report_events[$];
  key_ev_t               key_events_due[$];

  // random report generator state
  logic [7:0]            gen_mods;
  logic [SLOTS-1:0][7:0] gen_keys;

  int        err_cnt;
  int        in_idle_pct;
  int        out_idle_pct;
  bit        hold_off_req;
  key_ev_t   due_ev;
  stim_row_t dir_tab [DIR_ROWS];

  always #(CLK_PERIOD / 2) clk = ~clk;

  hid_report_to_key_events_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  function automatic key_ev_t key_ev(input logic d, input logic [7:0] v, input logic l);
    key_ev_t e;
    e.down = d;
    e.vk   = v;
    e.last = l;
    return e;
  endfunction

  function automatic logic [7:0] usage_vk(input logic [7:0] code);
    if (int'(code) >= USAGE_CODES) return 8'h00;
    return VK_OF_USAGE[code];
  endfunction

  function automatic bit slot_holds(input logic [SLOTS-1:0][7:0] list, input logic [7:0] code);
    for (int j = 0; j < SLOTS; j++) begin
      if (list[j] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // events for one report against the held one, then the report becomes the held one
  function void diff_report(input logic [55:0] w);
    logic [7:0]            mods;
    logic [SLOTS-1:0][7:0] keys;
    logic [7:0]            vk;
    key_ev_t               tail;
    report_events.delete();
    mods = w[7:0];
    keys = w[55:8];
    for (int m = 0; m < 6; m++) begin
      if (mods[MOD_BIT[m]] != held_mods[MOD_BIT[m]]) begin
        report_events.push_back(key_ev(mods[MOD_BIT[m]], MOD_KEYS[m], 1'b0));
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (keys[i] != 8'h00 && !slot_holds(held_keys, keys[i])) begin
        vk = usage_vk(keys[i]);
        if (vk != 8'h00) report_events.push_back(key_ev(1'b1, vk, 1'b0));
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (held_keys[i] != 8'h00 && !slot_holds(keys, held_keys[i])) begin
        vk = usage_vk(held_keys[i]);
        if (vk != 8'h00) report_events.push_back(key_ev(1'b0, vk, 1'b0));
      end
    end
    if (report_events.size() > 0) begin
      tail = report_events.pop_back();
      tail.last = 1'b1;
      report_events.push_back(tail);
    end
    held_mods = mods;
    held_keys = keys;
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 78) return 8'($urandom_range(8'h65, 4));
    if (r < 86) return 8'($urandom_range(8'h89, 8'h87));
    if (r < 92) return 8'($urandom_range(3, 1));
    return 8'($urandom_range(255));
  endfunction

  // mostly a keyboard evolving one or two slots at a time, some noise and odd reports
  function logic [55:0] next_report();
    logic [55:0] w;
    int          r;
    int          s;
    r = $urandom_range(99);
    if (r < 8) begin
      w = 56'({$urandom, $urandom});
      gen_mods = w[7:0];
      gen_keys = w[55:8];
    end else if (r < 14) begin
      s = $urandom_range(SLOTS - 1);
      gen_keys[s] = gen_keys[$urandom_range(SLOTS - 1)];
      gen_keys[$urandom_range(SLOTS - 1)] = 8'($urandom_range(8'hFF, 8'h66));
    end else begin
      if ($urandom_range(3) == 0) gen_mods = gen_mods ^ 8'(1 << $urandom_range(7));
      repeat ($urandom_range(2, 1)) begin
        s = $urandom_range(SLOTS - 1);
        if ($urandom_range(2) == 0) begin
          gen_keys[s] = 8'h00;
        end else begin
          gen_keys[s] = pick_code();
        end
      end
      if ($urandom_range(19) == 0) gen_keys = '0;
    end
    return {gen_keys, gen_mods};
  endfunction

  task automatic count_fault(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // offer one report, and once it is taken queue the events it should cause
  task automatic send_report(input logic [55:0] w, input int n_typed,
                             input key_ev_t e0, input key_ev_t e1);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    diff_report(w);
    if (n_typed == COMPUTED) begin
      foreach (report_events[i]) key_events_due.push_back(report_events[i]);
    end else begin
      if (n_typed > 0) key_events_due.push_back(e0);
      if (n_typed > 1) key_events_due.push_back(e1);
    end
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // event checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (key_events_due.size() == 0) begin
        count_fault($sformatf("unexpected event: down=%0d vk=%02h last=%0d",
                              out_tuser, out_tdata, out_tlast));
      end else begin
        due_ev = key_events_due.pop_front();
        if (out_tuser !== due_ev.down || out_tdata !== due_ev.vk ||
            out_tlast !== due_ev.last) begin
          count_fault($sformatf("event mismatch: exp down=%0d vk=%02h last=%0d, got down=%0d vk=%02h last=%0d",
                                due_ev.down, due_ev.vk, due_ev.last,
                                out_tuser, out_tdata, out_tlast));
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    held_mods    = '0;
    held_keys    = '0;
    gen_mods     = '0;
    gen_keys     = '0;
    err_cnt      = 0;
    in_idle_pct  = 25;
    out_idle_pct = 25;
    hold_off_req = 1'b0;

    // report word is {slot5 .. slot0, modifiers}
    dir_tab = '{
      '{{48'h0000_0000_0000, 8'h00}, 0, NO_EV, NO_EV},
      '{{48'h0000_0000_0004, 8'h01}, 2, key_ev(1'b1, 8'h11, 1'b0), key_ev(1'b1, 8'h41, 1'b1)},
      '{{48'h0000_0000_0000, 8'h00}, 2, key_ev(1'b0, 8'h11, 1'b0), key_ev(1'b0, 8'h41, 1'b1)},
      '{{48'h0000_0000_0000, 8'h88}, 0, NO_EV, NO_EV},
      '{{48'h0000_0000_0000, 8'h00}, 0, NO_EV, NO_EV},
      '{{48'h0000_0000_0000, 8'h77}, COMPUTED, NO_EV, NO_EV},
      '{{48'h0000_0000_0000, 8'hFF}, 0, NO_EV, NO_EV},
      '{{48'h0000_0000_0000, 8'h00}, COMPUTED, NO_EV, NO_EV},
      '{{48'h0000_0000_00FF, 8'h00}, 0, NO_EV, NO_EV},
      '{{48'h0000_0000_0089, 8'h00}, 1, key_ev(1'b1, 8'hDC, 1'b1), NO_EV},
      '{{48'h0000_0000_0053, 8'h00}, 1, key_ev(1'b0, 8'hDC, 1'b1), NO_EV},
      '{{48'h0404_0404_0404, 8'h00}, COMPUTED, NO_EV, NO_EV},
      '{{48'h0400_0000_0000, 8'h00}, 0, NO_EV, NO_EV},
      '{{48'h0000_0000_0000, 8'h00}, COMPUTED, NO_EV, NO_EV},
      '{{48'h0908_0706_0504, 8'h77}, COMPUTED, NO_EV, NO_EV},
      // every modifier, press and release at once
      '{{48'h0F0E_0D0C_0B0A, 8'h00}, COMPUTED, NO_EV, NO_EV},
      '{{48'h0F0E_0D0C_0B0A, 8'h00}, 0, NO_EV, NO_EV},
      '{{48'h0000_0003_0201, 8'h00}, COMPUTED, NO_EV, NO_EV},
      '{{48'h0000_6588_878A, 8'h40}, COMPUTED, NO_EV, NO_EV},
      '{{48'hFFFF_FFFF_FFFF, 8'hFF}, COMPUTED, NO_EV, NO_EV},
      '{{48'h0000_0000_0000, 8'h00}, COMPUTED, NO_EV, NO_EV},
      '{{48'h2C28_2A29_E0E1, 8'h12}, COMPUTED, NO_EV, NO_EV}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_report(dir_tab[r].report, dir_tab[r].n_typed, dir_tab[r].ev0, dir_tab[r].ev1);
    end

    gen_mods = held_mods;
    gen_keys = held_keys;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 40) hold_off_req = 1'b1;
      if (n == 200) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (n == 280) begin
        in_idle_pct  = 25;
        out_idle_pct = 25;
      end
      send_report(next_report(), COMPUTED, NO_EV, NO_EV);
    end
    in_tvalid <= 1'b0;

    while (key_events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/hrke_pkg.sv
design/hrke_event_gen.sv
design/hrke_serializer.sv
design/hid_report_to_key_events_top.sv
tb/sv/tb_top.sv
